// ===== hdl/htfc_pkg.sv =====
package htfc_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned RAW_W       = 20;
    localparam int unsigned HUM_W       = 10;
    localparam int unsigned TEMP_W      = 12;
    localparam int unsigned POS_W       = 3;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [POS_W-1:0]  POS_LAST = 3'd6;

    localparam logic [POS_W-1:0]  POS_HUM_HI  = 3'd1;
    localparam logic [POS_W-1:0]  POS_HUM_MID = 3'd2;
    localparam logic [POS_W-1:0]  POS_SPLIT   = 3'd3;
    localparam logic [POS_W-1:0]  POS_TEMP_MID = 3'd4;
    localparam logic [POS_W-1:0]  POS_TEMP_LO = 3'd5;

    localparam logic [9:0]  HUM_SCALE   = 10'd1000;
    localparam logic [10:0] TEMP_SCALE  = 11'd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 12'sd500;

    // One complete frame, as handed from the front end to the converter
    typedef struct packed {
        logic [RAW_W-1:0]  raw_hum;
        logic [RAW_W-1:0]  raw_temp;
        logic              crc_ok;
        logic [BYTE_W-1:0] crc_six;
    } t_frame;

    // CRC-8, MSB first, one byte
    function automatic logic [BYTE_W-1:0] crc_feed(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/htfc_front.sv =====
module htfc_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [htfc_pkg::BYTE_W-1:0]  i_frame_byte,
    input  logic                         i_queue_full,
    output logic                         o_push,
    output htfc_pkg::t_frame             o_frame
);
    import htfc_pkg::*;

    logic [BYTE_W-1:0] r_crc, n_crc;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [RAW_W-1:0]  r_raw_hum, n_raw_hum;
    logic [RAW_W-1:0]  r_raw_temp, n_raw_temp;
    logic [BYTE_W-1:0] r_crc_six, n_crc_six;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] crc_new;
    logic              accept;

    assign o_stall = i_queue_full;
    assign accept  = i_valid && !i_queue_full;
    // an out-of-range count restarts the frame
    assign pos     = (r_pos > POS_LAST) ? '0 : r_pos;
    assign crc_new = crc_feed(r_crc, i_frame_byte);

    always_comb begin
        n_crc      = r_crc;
        n_pos      = r_pos;
        n_raw_hum  = r_raw_hum;
        n_raw_temp = r_raw_temp;
        n_crc_six  = r_crc_six;
        if (accept) begin
            n_crc = crc_new;
            case (pos)
                POS_HUM_HI: begin
                    n_raw_hum = {i_frame_byte, 12'd0};
                end
                POS_HUM_MID: begin
                    n_raw_hum = r_raw_hum | {8'd0, i_frame_byte, 4'd0};
                end
                POS_SPLIT: begin
                    n_raw_hum  = r_raw_hum | {16'd0, i_frame_byte[7:4]};
                    n_raw_temp = {i_frame_byte[3:0], 16'd0};
                end
                POS_TEMP_MID: begin
                    n_raw_temp = r_raw_temp | {4'd0, i_frame_byte, 8'd0};
                end
                POS_TEMP_LO: begin
                    n_raw_temp = r_raw_temp | {12'd0, i_frame_byte};
                    n_crc_six  = crc_new;
                end
                default: begin
                end
            endcase
            if (pos == POS_LAST) begin
                n_crc = CRC_INIT;
                n_pos = '0;
            end else begin
                n_pos = pos + 1'b1;
            end
        end
    end

    assign o_push           = accept && (pos == POS_LAST);
    assign o_frame.raw_hum  = r_raw_hum;
    assign o_frame.raw_temp = r_raw_temp;
    assign o_frame.crc_ok   = (crc_new == '0);
    assign o_frame.crc_six  = r_crc_six;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
            r_pos <= '0;
        end else begin
            r_crc <= n_crc;
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw_hum  <= n_raw_hum;
        r_raw_temp <= n_raw_temp;
        r_crc_six  <= n_crc_six;
    end

endmodule

// ===== hdl/htfc_queue.sv =====
module htfc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  htfc_pkg::t_frame i_frame,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_not_empty,
    output htfc_pkg::t_frame o_frame
);
    import htfc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_frame            r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push_ok, pop_ok;

    assign o_full      = (r_count == CNT_FULL);
    assign o_not_empty = (r_count != '0);
    assign push_ok     = i_push && !o_full;
    assign pop_ok      = i_pop && o_not_empty;
    assign o_frame     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/htfc_back.sv =====
module htfc_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_not_empty,
    input  htfc_pkg::t_frame                   i_frame,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [htfc_pkg::HUM_W-1:0]         o_humidity_tenths,
    output logic signed [htfc_pkg::TEMP_W-1:0] o_temperature_tenths,
    output logic                               o_crc_ok,
    output logic [htfc_pkg::BYTE_W-1:0]        o_computed_crc
);
    import htfc_pkg::*;

    logic                      r_valid;
    logic [HUM_W-1:0]          r_hum;
    logic signed [TEMP_W-1:0]  r_temp;
    logic                      r_ok;
    logic [BYTE_W-1:0]         r_crc;
    logic [HUM_W-1:0]          n_hum;
    logic signed [TEMP_W-1:0]  n_temp;
    logic [RAW_W+HUM_W-1:0]    hum_prod;
    logic [RAW_W+10:0]         temp_prod;
    logic [10:0]               temp_scaled;

    // load a new frame whenever the output slot is empty or being emptied
    assign o_pop = i_not_empty && (!r_valid || !i_stall);

    assign hum_prod    = i_frame.raw_hum * HUM_SCALE;
    assign temp_prod   = i_frame.raw_temp * TEMP_SCALE;
    assign temp_scaled = temp_prod[RAW_W+10:RAW_W];

    always_comb begin
        if (i_frame.crc_ok) begin
            n_hum  = hum_prod[RAW_W+HUM_W-1:RAW_W];
            n_temp = $signed({1'b0, temp_scaled}) - TEMP_OFFSET;
        end else begin
            n_hum  = '0;
            n_temp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hum  <= n_hum;
            r_temp <= n_temp;
            r_ok   <= i_frame.crc_ok;
            r_crc  <= i_frame.crc_six;
        end
    end

    assign o_valid              = r_valid;
    assign o_humidity_tenths    = r_hum;
    assign o_temperature_tenths = r_temp;
    assign o_crc_ok             = r_ok;
    assign o_computed_crc       = r_crc;

endmodule

// ===== hdl/humidity_temp_frame_check_convert_unit.sv =====
// Measurement frame checker and converter. Takes one byte per cycle on the
// input transfer while not stalled, seven bytes to a frame (status, five
// data bytes, CRC), counted from reset with no resynchronisation. The front
// end runs the CRC-8 (polynomial 0x31, start 0xFF) and assembles the 20-bit
// raw humidity and temperature; on the seventh byte it pushes the whole
// frame into a small queue (QUEUE_DEPTH frames). The back end scales each
// frame with one multiplier per value into an output register: humidity
// and temperature in tenths, the latter signed with an offset of -50.0 C,
// both zero on a CRC error, plus the CRC over the first six bytes. A result
// is offered after passing through the queue and then the output register.
// Input stall rises only while the queue holds QUEUE_DEPTH unread frames,
// so, output taken as offered, it sustains one byte per cycle indefinitely.
module humidity_temp_frame_check_convert_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [htfc_pkg::BYTE_W-1:0]        i_frame_byte,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [htfc_pkg::HUM_W-1:0]         o_humidity_tenths,
    output logic signed [htfc_pkg::TEMP_W-1:0] o_temperature_tenths,
    output logic                               o_crc_ok,
    output logic [htfc_pkg::BYTE_W-1:0]        o_computed_crc
);
    import htfc_pkg::*;

    t_frame push_frame, pop_frame;
    logic   push, pop, queue_full, queue_not_empty;

    // Front end: accept bytes, run the CRC, assemble the raw fields
    htfc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_frame_byte (i_frame_byte),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_frame      (push_frame)
    );

    // Hold complete frames so either side can stall on its own
    htfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_frame     (push_frame),
        .o_full      (queue_full),
        .i_pop       (pop),
        .o_not_empty (queue_not_empty),
        .o_frame     (pop_frame)
    );

    // Back end: scale, zero on CRC failure, present the result transfer
    htfc_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_not_empty          (queue_not_empty),
        .i_frame              (pop_frame),
        .o_pop                (pop),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_humidity_tenths    (o_humidity_tenths),
        .o_temperature_tenths (o_temperature_tenths),
        .o_crc_ok             (o_crc_ok),
        .o_computed_crc       (o_computed_crc)
    );

endmodule
